[sv/stl_pkg.sv]
// ----------------------------------------------------------------------------
// stl_pkg: shared constants of the source token lexer
// Character codes, token kinds, output word layout and queue depth.
// ----------------------------------------------------------------------------
package stl_pkg;

  // characters with a special role
  localparam logic [7:0] CH_EQ      = 8'h3D;  // '='
  localparam logic [7:0] CH_UNDER   = 8'h5F;  // '_'
  localparam logic [7:0] CH_DOT     = 8'h2E;  // '.'
  localparam logic [7:0] CH_QUOTE   = 8'h22;  // '"'
  localparam logic [7:0] CH_NEWLINE = 8'h0A;  // '\n'

  // operator base kinds; the '=' form is base plus one
  localparam logic [4:0] KIND_PLUS    = 5'd0;
  localparam logic [4:0] KIND_MINUS   = 5'd2;
  localparam logic [4:0] KIND_SLASH   = 5'd4;
  localparam logic [4:0] KIND_STAR    = 5'd6;
  localparam logic [4:0] KIND_LESS    = 5'd8;
  localparam logic [4:0] KIND_GREATER = 5'd10;
  localparam logic [4:0] KIND_BANG    = 5'd12;
  localparam logic [4:0] KIND_ASSIGN  = 5'd14;

  // single punctuation
  localparam logic [4:0] KIND_COLON  = 5'd16;
  localparam logic [4:0] KIND_SEMI   = 5'd17;
  localparam logic [4:0] KIND_DOT    = 5'd18;
  localparam logic [4:0] KIND_COMMA  = 5'd19;
  localparam logic [4:0] KIND_LPAREN = 5'd20;
  localparam logic [4:0] KIND_RPAREN = 5'd21;
  localparam logic [4:0] KIND_LBRACK = 5'd22;
  localparam logic [4:0] KIND_RBRACK = 5'd23;
  localparam logic [4:0] KIND_LBRACE = 5'd24;
  localparam logic [4:0] KIND_RBRACE = 5'd25;

  // token kinds beyond operators and punctuation
  localparam logic [4:0] KIND_STRING = 5'd26;
  localparam logic [4:0] KIND_NUMBER = 5'd27;
  localparam logic [4:0] KIND_IDENT  = 5'd28;
  localparam logic [4:0] KIND_END    = 5'd29;

  // output fields
  localparam int KIND_W  = 5;
  localparam int FIELD_W = 20;
  localparam int LINE_W  = 20;
  localparam int OUT_W   = 80;  // start, length, end and line, whole bytes
  localparam int IN_W    = 8;

  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

  // results per input byte, and entries in the front-to-back queue
  localparam int SLOTS       = 3;
  localparam int QUEUE_DEPTH = 4;

endpackage

[sv/stl_front.sv]
// ----------------------------------------------------------------------------
// stl_front: byte classifier and scanner state
// Accepts one byte a cycle while the queue has room, tracks the token in progress
// and builds an entry of up to three tokens for the back end.
// ----------------------------------------------------------------------------
module stl_front #(
  parameter int OFFSET_BITS = 20,
  localparam int TOK_W   = stl_pkg::KIND_W + 2 * OFFSET_BITS + stl_pkg::LINE_W + 1,
  localparam int ENTRY_W = stl_pkg::SLOTS + stl_pkg::SLOTS * TOK_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_final,
  input  logic               q_ready,
  output logic               push,
  output logic [ENTRY_W-1:0] push_entry
);

  typedef struct packed {
    logic [stl_pkg::KIND_W-1:0] kind;
    logic [OFFSET_BITS-1:0]     start;
    logic [OFFSET_BITS-1:0]     stop;
    logic [stl_pkg::LINE_W-1:0] line;
    logic                       last;
  } tok_t;

  typedef struct packed {
    logic [stl_pkg::SLOTS-1:0] mask;
    tok_t [stl_pkg::SLOTS-1:0] tok;
  } entry_t;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_OPER  = 3'd1,
    M_STR   = 3'd2,
    M_IDENT = 3'd3,
    M_NUM   = 3'd4
  } mode_t;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

  mode_t                      mode, mode_next;
  logic [4:0]                 pending_kind, pending_kind_next;
  logic [OFFSET_BITS-1:0]     token_begin, token_begin_next;
  logic [OFFSET_BITS-1:0]     byte_offset;
  logic [stl_pkg::LINE_W-1:0] line_count, line_count_next;

  logic [OFFSET_BITS-1:0] here, next;
  logic                   accept, consumed;
  logic                   op_hit, punct_hit, is_letter, is_digit;
  logic [4:0]             op_kind, punct_kind;
  entry_t                 entry;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;

  // map operator and punctuation bytes to their kinds
  always_comb begin
    op_hit  = 1'b1;
    op_kind = stl_pkg::KIND_PLUS;
    unique case (in_byte)
      8'h2B:   op_kind = stl_pkg::KIND_PLUS;     // +
      8'h2D:   op_kind = stl_pkg::KIND_MINUS;    // -
      8'h2F:   op_kind = stl_pkg::KIND_SLASH;    // /
      8'h2A:   op_kind = stl_pkg::KIND_STAR;     // *
      8'h3C:   op_kind = stl_pkg::KIND_LESS;     // <
      8'h3E:   op_kind = stl_pkg::KIND_GREATER;  // >
      8'h21:   op_kind = stl_pkg::KIND_BANG;     // !
      8'h3D:   op_kind = stl_pkg::KIND_ASSIGN;   // =
      default: op_hit  = 1'b0;
    endcase
    punct_hit  = 1'b1;
    punct_kind = stl_pkg::KIND_COLON;
    unique case (in_byte)
      8'h3A:   punct_kind = stl_pkg::KIND_COLON;   // :
      8'h3B:   punct_kind = stl_pkg::KIND_SEMI;    // ;
      8'h2E:   punct_kind = stl_pkg::KIND_DOT;     // .
      8'h2C:   punct_kind = stl_pkg::KIND_COMMA;   // ,
      8'h28:   punct_kind = stl_pkg::KIND_LPAREN;  // (
      8'h29:   punct_kind = stl_pkg::KIND_RPAREN;  // )
      8'h5B:   punct_kind = stl_pkg::KIND_LBRACK;  // [
      8'h5D:   punct_kind = stl_pkg::KIND_RBRACK;  // ]
      8'h7B:   punct_kind = stl_pkg::KIND_LBRACE;  // {
      8'h7D:   punct_kind = stl_pkg::KIND_RBRACE;  // }
      default: punct_hit  = 1'b0;
    endcase
  end

  assign is_letter = (in_byte >= 8'h61 && in_byte <= 8'h7A) ||
                     (in_byte >= 8'h41 && in_byte <= 8'h5A);
  assign is_digit  = in_byte >= 8'h30 && in_byte <= 8'h39;

  assign here = byte_offset;
  assign next = (byte_offset == OFFSET_MAX) ? byte_offset : byte_offset + 1'b1;

  // scan one byte: close the running token, start a new one, flush at end
  always_comb begin
    mode_next         = mode;
    pending_kind_next = pending_kind;
    token_begin_next  = token_begin;
    line_count_next   = line_count;
    consumed          = 1'b1;
    entry             = '0;

    unique case (mode)
      M_STR: begin
        if (in_byte == stl_pkg::CH_QUOTE) begin
          entry.mask[0] = 1'b1;
          entry.tok[0]  = '{stl_pkg::KIND_STRING, token_begin, here, line_count, 1'b0};
          mode_next     = M_IDLE;
        end
      end
      M_IDENT: begin
        if (!(is_letter || in_byte == stl_pkg::CH_UNDER)) begin
          entry.mask[0] = 1'b1;
          entry.tok[0]  = '{stl_pkg::KIND_IDENT, token_begin, here, line_count, 1'b0};
          mode_next     = M_IDLE;
          consumed      = 1'b0;
        end
      end
      M_NUM: begin
        if (!(is_digit || in_byte == stl_pkg::CH_DOT)) begin
          entry.mask[0] = 1'b1;
          entry.tok[0]  = '{stl_pkg::KIND_NUMBER, token_begin, here, line_count, 1'b0};
          mode_next     = M_IDLE;
          consumed      = 1'b0;
        end
      end
      M_OPER: begin
        entry.mask[0] = 1'b1;
        if (in_byte == stl_pkg::CH_EQ) begin
          entry.tok[0] = '{pending_kind + 5'd1, token_begin, next, line_count, 1'b0};
        end else begin
          entry.tok[0] = '{pending_kind, token_begin, here, line_count, 1'b0};
          consumed     = 1'b0;
        end
        mode_next = M_IDLE;
      end
      default: begin
        mode_next = M_IDLE;
        consumed  = 1'b0;
      end
    endcase

    // handle the byte again from idle
    if (!consumed) begin
      priority if (op_hit) begin
        mode_next         = M_OPER;
        pending_kind_next = op_kind;
        token_begin_next  = here;
      end else if (punct_hit) begin
        entry.mask[1] = 1'b1;
        entry.tok[1]  = '{punct_kind, here, next, line_count, 1'b0};
      end else if (in_byte == stl_pkg::CH_QUOTE) begin
        mode_next        = M_STR;
        token_begin_next = next;
      end else if (in_byte == stl_pkg::CH_NEWLINE) begin
        if (line_count != stl_pkg::LINE_MAX) begin
          line_count_next = line_count + 1'b1;
        end
      end else if (is_letter) begin
        mode_next        = M_IDENT;
        token_begin_next = here;
      end else if (is_digit) begin
        mode_next        = M_NUM;
        token_begin_next = here;
      end else begin
        mode_next = mode_next;
      end
    end

    // end of text: flush the pending token, then close the stream
    if (in_final) begin
      unique case (mode_next)
        M_OPER: begin
          entry.mask[1] = 1'b1;
          entry.tok[1]  = '{pending_kind_next, token_begin_next, next, line_count_next, 1'b0};
        end
        M_STR: begin
          entry.mask[1] = 1'b1;
          entry.tok[1]  = '{stl_pkg::KIND_STRING, token_begin_next, next, line_count_next,
                            1'b0};
        end
        M_IDENT: begin
          entry.mask[1] = 1'b1;
          entry.tok[1]  = '{stl_pkg::KIND_IDENT, token_begin_next, next, line_count_next,
                            1'b0};
        end
        M_NUM: begin
          entry.mask[1] = 1'b1;
          entry.tok[1]  = '{stl_pkg::KIND_NUMBER, token_begin_next, next, line_count_next,
                            1'b0};
        end
        default: begin
          entry.mask[1] = entry.mask[1];
        end
      endcase
      entry.mask[2] = 1'b1;
      entry.tok[2]  = '{stl_pkg::KIND_END, next, next, line_count_next, 1'b1};
    end
  end

  assign push       = accept && (entry.mask != '0);
  assign push_entry = entry;

  // hold scanner state; a final byte returns everything to reset
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      pending_kind <= '0;
      token_begin  <= '0;
      byte_offset  <= '0;
      line_count   <= '0;
    end else if (accept) begin
      if (in_final) begin
        mode         <= M_IDLE;
        pending_kind <= '0;
        token_begin  <= '0;
        byte_offset  <= '0;
        line_count   <= '0;
      end else begin
        mode         <= mode_next;
        pending_kind <= pending_kind_next;
        token_begin  <= token_begin_next;
        byte_offset  <= next;
        line_count   <= line_count_next;
      end
    end
  end

endmodule

[sv/stl_queue.sv]
// ----------------------------------------------------------------------------
// stl_queue: short queue between scanner and token output
// Holds token groups so either side can stall on its own.
// ----------------------------------------------------------------------------
module stl_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int DEPTH = stl_pkg::QUEUE_DEPTH;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [IDX_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign not_full   = count != CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_data  = slots[rd_ptr];
  assign do_push    = push && not_full;
  assign do_pop     = pop && head_valid;

  // store incoming groups
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/stl_back.sv]
// ----------------------------------------------------------------------------
// stl_back: token serializer and output register
// Formats the output fields; unpacks groups one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module stl_back #(
  parameter int OFFSET_BITS = 20,
  localparam int TOK_W   = stl_pkg::KIND_W + 2 * OFFSET_BITS + stl_pkg::LINE_W + 1,
  localparam int ENTRY_W = stl_pkg::SLOTS + stl_pkg::SLOTS * TOK_W
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  logic [ENTRY_W-1:0]         head_data,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [stl_pkg::OUT_W-1:0]  out_data,
  output logic [stl_pkg::KIND_W-1:0] out_user,
  output logic                       out_last
);

  typedef struct packed {
    logic [stl_pkg::KIND_W-1:0] kind;
    logic [OFFSET_BITS-1:0]     start;
    logic [OFFSET_BITS-1:0]     stop;
    logic [stl_pkg::LINE_W-1:0] line;
    logic                       last;
  } tok_t;

  typedef struct packed {
    logic [stl_pkg::SLOTS-1:0] mask;
    tok_t [stl_pkg::SLOTS-1:0] tok;
  } entry_t;

  entry_t                    cur;
  logic [stl_pkg::SLOTS-1:0] mask_after;
  tok_t                      sel;
  logic [OFFSET_BITS-1:0]    len_full;
  logic                      load;
  logic [31:0]               start32, stop32, len32;

  assign load = (!out_valid || out_ready) && (cur.mask != '0);

  // pick the lowest pending token of the current group
  always_comb begin
    mask_after = cur.mask;
    sel        = cur.tok[0];
    priority if (cur.mask[0]) begin
      sel           = cur.tok[0];
      mask_after[0] = !load;
    end else if (cur.mask[1]) begin
      sel           = cur.tok[1];
      mask_after[1] = !load;
    end else if (cur.mask[2]) begin
      sel           = cur.tok[2];
      mask_after[2] = !load;
    end else begin
      sel = cur.tok[0];
    end
  end

  assign pop = head_valid && (mask_after == '0);

  // length clamps at zero once offsets have saturated
  assign len_full = (sel.stop >= sel.start) ? sel.stop - sel.start : '0;
  assign start32  = 32'(sel.start);
  assign stop32   = 32'(sel.stop);
  assign len32    = 32'(len_full);

  // hold the current group
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.mask <= '0;
    end else if (pop) begin
      cur <= head_data;
    end else begin
      cur.mask <= mask_after;
    end
  end

  // output register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= cur.mask != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= {sel.line, stop32[stl_pkg::FIELD_W-1:0], len32[stl_pkg::FIELD_W-1:0],
                   start32[stl_pkg::FIELD_W-1:0]};
      out_user <= sel.kind;
      out_last <= sel.last;
    end
  end

endmodule

[sv/source_token_lexer.sv]
// ----------------------------------------------------------------------------
// source_token_lexer: streaming source text tokenizer
// One text byte per input word in, one token per output word out.
// ----------------------------------------------------------------------------
// Input channel s_*: tdata carries the text byte, tlast marks the last byte of
// a text. Output channel m_*: tuser carries the token kind, tdata carries
// start, length, end offset and line; tlast marks the end marker of a text.
// A byte is taken every cycle while the token queue has room. Each byte makes
// zero to three tokens (close of the running token, a punctuation or flushed
// token, and the end marker on the final byte). Tokens leave at one per
// cycle while the receiver is ready, so sustained rate is one byte a cycle
// while tokens average at most one per byte; the single output register sets
// that bound. A byte's tokens are written into the queue as one group at the
// edge that takes the byte, then pass through the group register into the
// output register. Operators wait for the next byte, or the end of the text,
// before they are emitted. Reset clears the scanner, the queue and the output
// valid. When the receiver stalls the output word holds, the queue fills, and
// s_tready drops once all four queue entries are in use.
// ----------------------------------------------------------------------------
module source_token_lexer #(
  parameter int OFFSET_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [19:0] text_start, [39:20] text_length,
                                 // [59:40] end_offset, [79:60] line_number
  output logic [4:0]  m_tuser,   // [4:0] token_kind
  output logic        m_tlast    // last_token
);

  localparam int TOK_W   = stl_pkg::KIND_W + 2 * OFFSET_BITS + stl_pkg::LINE_W + 1;
  localparam int ENTRY_W = stl_pkg::SLOTS + stl_pkg::SLOTS * TOK_W;

  logic               q_ready, push, pop, head_valid;
  logic [ENTRY_W-1:0] push_entry, head_data;

  // scan bytes into token groups
  stl_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_final   (s_tlast),
    .q_ready    (q_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  // decouple scanning from output
  stl_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_entry),
    .not_full   (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // emit one token word per cycle while the receiver is ready
  stl_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_user   (m_tuser),
    .out_last   (m_tlast)
  );

endmodule

[sv/stl_checker.sv]
// ----------------------------------------------------------------------------
// stl_checker: port-level checks for the source token lexer
// Watches the output channel for reset, hold and end-marker rules.
// ----------------------------------------------------------------------------
module stl_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [4:0]  m_tuser,
  input logic        m_tlast
);

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("output word changed under stall");

  // the end marker carries its kind and an empty text
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == stl_pkg::KIND_END && m_tdata[39:20] == 20'd0)
    else $error("last word is not an empty end marker");

  // every end marker closes the stream
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == stl_pkg::KIND_END |-> m_tlast)
    else $error("end marker without last flag");

  // no kind beyond the end marker
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= stl_pkg::KIND_END)
    else $error("token kind out of range");

endmodule

bind source_token_lexer stl_checker u_stl_checker (.*);

[tb/lexer_checker.sv]
// ----------------------------------------------------------------------------
// lexer_checker: token predictor and scoreboard for source_token_lexer
// Runs every byte taken on the input channel through its own copy of the
// scanner, queues the tokens that byte implies, and compares each token taken
// on the output channel with the oldest queued one.
// ----------------------------------------------------------------------------
module lexer_checker #(
  parameter int OFFSET_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] char_byte
  input  logic                       s_tlast,   // final_byte
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [stl_pkg::OUT_W-1:0]  m_tdata,   // [19:0] start, [39:20] length,
                                                // [59:40] end, [79:60] line
  input  logic [stl_pkg::KIND_W-1:0] m_tuser,   // [4:0] kind
  input  logic                       m_tlast,   // last_token
  output int                         mismatches,
  output int                         tokens_waiting,
  output int                         tokens_checked
);

  // no kind: byte is neither operator nor punctuation
  localparam logic [stl_pkg::KIND_W-1:0] KIND_NONE = 5'd31;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_OPER, SCAN_STRING, SCAN_IDENT, SCAN_NUMBER
  } scan_t;

  // one token as it appears on the output: tlast, tdata fields, then tuser
  typedef struct packed {
    logic                        last;
    logic [stl_pkg::LINE_W-1:0]  line;
    logic [stl_pkg::FIELD_W-1:0] end_off;
    logic [stl_pkg::FIELD_W-1:0] length;
    logic [stl_pkg::FIELD_W-1:0] start;
    logic [stl_pkg::KIND_W-1:0]  kind;
  } token_t;

  token_t predicted_tokens[$];

  scan_t                      mode;
  logic [stl_pkg::KIND_W-1:0] op_kind;
  logic [OFFSET_BITS-1:0]     tok_start;
  logic [OFFSET_BITS-1:0]     cur_off;
  logic [stl_pkg::LINE_W-1:0] line_cnt;

  int bad_count = 0;
  int good_count = 0;

  function automatic logic [stl_pkg::KIND_W-1:0] operator_base(input logic [7:0] c);
    case (c)
      "+":            return stl_pkg::KIND_PLUS;
      "-":            return stl_pkg::KIND_MINUS;
      "/":            return stl_pkg::KIND_SLASH;
      "*":            return stl_pkg::KIND_STAR;
      "<":            return stl_pkg::KIND_LESS;
      ">":            return stl_pkg::KIND_GREATER;
      "!":            return stl_pkg::KIND_BANG;
      stl_pkg::CH_EQ: return stl_pkg::KIND_ASSIGN;
      default:        return KIND_NONE;
    endcase
  endfunction

  function automatic logic [stl_pkg::KIND_W-1:0] punct_of(input logic [7:0] c);
    case (c)
      ":":             return stl_pkg::KIND_COLON;
      ";":             return stl_pkg::KIND_SEMI;
      stl_pkg::CH_DOT: return stl_pkg::KIND_DOT;
      ",":             return stl_pkg::KIND_COMMA;
      "(":             return stl_pkg::KIND_LPAREN;
      ")":             return stl_pkg::KIND_RPAREN;
      "[":             return stl_pkg::KIND_LBRACK;
      "]":             return stl_pkg::KIND_RBRACK;
      "{":             return stl_pkg::KIND_LBRACE;
      "}":             return stl_pkg::KIND_RBRACE;
      default:         return KIND_NONE;
    endcase
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic string token_text(input token_t t);
    return $sformatf("kind %0d start %0d len %0d end %0d line %0d last %0b",
                     t.kind, t.start, t.length, t.end_off, t.line, t.last);
  endfunction

  task automatic clear_scan();
    mode      = SCAN_IDLE;
    op_kind   = '0;
    tok_start = '0;
    cur_off   = '0;
    line_cnt  = '0;
  endtask

  // queue a token; length clamps to zero once saturated offsets cross
  task automatic push_token(input logic [stl_pkg::KIND_W-1:0] kind,
                            input logic [OFFSET_BITS-1:0] from,
                            input logic [OFFSET_BITS-1:0] upto,
                            input logic last);
    token_t t;
    t.kind    = kind;
    t.start   = stl_pkg::FIELD_W'(from);
    t.end_off = stl_pkg::FIELD_W'(upto);
    t.length  = (upto >= from) ? stl_pkg::FIELD_W'(upto - from) : '0;
    t.line    = line_cnt;
    t.last    = last;
    predicted_tokens.push_back(t);
  endtask

  // advance the scanner by one text byte and queue the tokens it closes
  task automatic scan_byte(input logic [7:0] c, input logic fin);
    logic [OFFSET_BITS-1:0]     here;
    logic [OFFSET_BITS-1:0]     next;
    logic                       taken;
    logic [stl_pkg::KIND_W-1:0] k;
    here  = cur_off;
    next  = (here != OFFSET_MAX) ? here + 1'b1 : here;
    taken = 1'b1;

    // offer the byte to the token in progress
    case (mode)
      SCAN_STRING: begin
        if (c == stl_pkg::CH_QUOTE) begin
          push_token(stl_pkg::KIND_STRING, tok_start, here, 1'b0);
          mode = SCAN_IDLE;
        end
      end
      SCAN_IDENT: begin
        if (!(is_letter(c) || c == stl_pkg::CH_UNDER)) begin
          push_token(stl_pkg::KIND_IDENT, tok_start, here, 1'b0);
          mode  = SCAN_IDLE;
          taken = 1'b0;
        end
      end
      SCAN_NUMBER: begin
        if (!(is_digit(c) || c == stl_pkg::CH_DOT)) begin
          push_token(stl_pkg::KIND_NUMBER, tok_start, here, 1'b0);
          mode  = SCAN_IDLE;
          taken = 1'b0;
        end
      end
      SCAN_OPER: begin
        if (c == stl_pkg::CH_EQ) begin
          push_token(op_kind + 1'b1, tok_start, next, 1'b0);
        end else begin
          push_token(op_kind, tok_start, here, 1'b0);
          taken = 1'b0;
        end
        mode = SCAN_IDLE;
      end
      default: begin
        mode  = SCAN_IDLE;
        taken = 1'b0;
      end
    endcase

    // handle a byte that was not absorbed from idle
    if (!taken) begin
      k = operator_base(c);
      if (k != KIND_NONE) begin
        mode      = SCAN_OPER;
        op_kind   = k;
        tok_start = here;
      end else begin
        k = punct_of(c);
        if (k != KIND_NONE) begin
          push_token(k, here, next, 1'b0);
        end else if (c == stl_pkg::CH_QUOTE) begin
          mode      = SCAN_STRING;
          tok_start = next;
        end else if (c == stl_pkg::CH_NEWLINE) begin
          if (line_cnt != stl_pkg::LINE_MAX) line_cnt = line_cnt + 1'b1;
        end else if (is_letter(c)) begin
          mode      = SCAN_IDENT;
          tok_start = here;
        end else if (is_digit(c)) begin
          mode      = SCAN_NUMBER;
          tok_start = here;
        end
      end
    end

    cur_off = next;

    // flush the pending token, close the text and start over
    if (fin) begin
      case (mode)
        SCAN_OPER:   push_token(op_kind, tok_start, next, 1'b0);
        SCAN_STRING: push_token(stl_pkg::KIND_STRING, tok_start, next, 1'b0);
        SCAN_IDENT:  push_token(stl_pkg::KIND_IDENT, tok_start, next, 1'b0);
        SCAN_NUMBER: push_token(stl_pkg::KIND_NUMBER, tok_start, next, 1'b0);
        default: ;
      endcase
      push_token(stl_pkg::KIND_END, next, next, 1'b1);
      clear_scan();
    end
  endtask

  // follow both channels and score every token taken
  always @(posedge clk) begin : watch
    token_t got;
    token_t want;
    if (rst) begin
      clear_scan();
      predicted_tokens.delete();
    end else begin
      if (s_tvalid && s_tready) scan_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        got = {m_tlast, m_tdata, m_tuser};
        if (predicted_tokens.size() == 0) begin
          if (bad_count < 10) $display("unexpected token: %s", token_text(got));
          bad_count++;
        end else begin
          want = predicted_tokens.pop_front();
          if (got !== want) begin
            if (bad_count < 10) begin
              $display("token %0d mismatch: expected %s", good_count + bad_count,
                       token_text(want));
              $display("  got %s", token_text(got));
            end
            bad_count++;
          end else begin
            good_count++;
          end
        end
      end
    end
    mismatches     <= bad_count;
    tokens_waiting <= predicted_tokens.size();
    tokens_checked <= good_count + bad_count;
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for source_token_lexer
// Feeds directed texts, then random texts built mostly from well-formed tokens
// with noise and broken strings mixed in, on a narrow offset counter. Both
// channels idle at random, except over a stretch at the start of the random
// texts. Scoring is left to lexer_checker.
// ----------------------------------------------------------------------------
module testbench;

  // narrow offset counter, zero-extended into the output fields
  localparam int OFFSET_BITS  = 8;
  localparam int RANDOM_BYTES = 70;
  localparam int QUIET_BYTES  = 30;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [7:0]                s_tdata = '0;
  logic                      s_tlast = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [stl_pkg::OUT_W-1:0] m_tdata;
  logic [4:0]                m_tuser;
  logic                      m_tlast;

  logic quiet = 1'b0;
  int   mismatches;
  int   tokens_waiting;
  int   tokens_checked;
  int   bytes_sent = 0;
  int   texts_sent = 0;

  logic [7:0] text_q[$];
  string op_chars    = "+-/*<>!=";
  string punct_chars = ":;.,()[]{}";
  string space_chars = " \t\n\n";

  source_token_lexer #(
    .OFFSET_BITS(OFFSET_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  lexer_checker #(
    .OFFSET_BITS(OFFSET_BITS)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .mismatches     (mismatches),
    .tokens_waiting (tokens_waiting),
    .tokens_checked (tokens_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // stall the token receiver now and then, never while quiet
  always @(posedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= 8);
  end

  // hard stop well past the slowest correct run
  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

  // offer one byte, hold it until taken, then maybe idle a cycle
  task automatic send_byte(input logic [7:0] b, input logic fin);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    if (!quiet && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // send the queued text with tlast on its last byte
  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
    texts_sent++;
  endtask

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] any_letter();
    return ($urandom_range(1) ? "a" : "A") + 8'($urandom_range(25));
  endfunction

  // append one random piece: mostly tokens, some whitespace and noise
  task automatic add_piece();
    int sel;
    int n;
    sel = $urandom_range(99);
    if (sel < 15) begin
      text_q.push_back(any_letter());
      n = $urandom_range(5);
      repeat (n) text_q.push_back($urandom_range(3) == 0 ? stl_pkg::CH_UNDER : any_letter());
    end else if (sel < 28) begin
      text_q.push_back("0" + 8'($urandom_range(9)));
      n = $urandom_range(4);
      repeat (n) text_q.push_back($urandom_range(3) == 0 ? stl_pkg::CH_DOT :
                                  "0" + 8'($urandom_range(9)));
    end else if (sel < 45) begin
      text_q.push_back(op_chars[$urandom_range(7)]);
      if ($urandom_range(1)) text_q.push_back(stl_pkg::CH_EQ);
    end else if (sel < 58) begin
      text_q.push_back(punct_chars[$urandom_range(9)]);
    end else if (sel < 68) begin
      // string with printable or newline content, sometimes left open
      text_q.push_back(stl_pkg::CH_QUOTE);
      n = $urandom_range(6);
      repeat (n) text_q.push_back($urandom_range(5) == 0 ? stl_pkg::CH_NEWLINE :
                                  8'($urandom_range(32, 126)));
      if ($urandom_range(99) < 85) text_q.push_back(stl_pkg::CH_QUOTE);
    end else if (sel < 82) begin
      text_q.push_back(space_chars[$urandom_range(3)]);
    end else begin
      text_q.push_back(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int pieces;
    int random_start;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: operator forms, lookahead miss, newline inside and outside a
    // string, operator flushed at end, open string, dropped high byte
    load_text("ab_+=3.5<x\n\"s\nq\"!");
    send_text();
    load_text("\"ab");
    send_text();
    text_q.push_back(8'hFF);
    send_text();
    load_text("==");
    send_text();

    // random texts; the first ones run without idling on either side
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      pieces = $urandom_range(1, 12);
      repeat (pieces) add_piece();
      quiet <= (bytes_sent - random_start < QUIET_BYTES);
      send_text();
    end
    s_tvalid <= 1'b0;
    quiet    <= 1'b0;

    // drain, then allow for the output pipeline
    do @(posedge clk); while (tokens_waiting != 0);
    repeat (20) @(posedge clk);

    $display("Lexed %0d bytes in %0d texts with %0d-bit offsets, both sides stalling.",
             bytes_sent, texts_sent, OFFSET_BITS);
    $display("Compared %0d tokens, %0d mismatched.", tokens_checked, mismatches);
    if (mismatches == 0 && tokens_waiting == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
